[rtl/irf_pkg.sv]
// shared types, constants and widths for the illinois root finder
package irf_pkg;

    // number format and derived widths
    localparam int DATA_WIDTH = 32;
    localparam int ITER_W     = 10;
    localparam int TOL_W      = DATA_WIDTH - 1;
    localparam int NUM_W      = 2 * DATA_WIDTH + 1;
    localparam int DEN_W      = DATA_WIDTH + 1;
    localparam int QUO_W      = DATA_WIDTH + 2;
    localparam int Q_W        = DATA_WIDTH + 3;
    localparam int XS_W       = DATA_WIDTH + 4;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int REG_IDX_W  = CFG_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_X_TOL      = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_Y_TOL      = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT = REG_IDX_W'(2);

    localparam logic [TOL_W-1:0]  X_TOL_RESET      = TOL_W'(0);
    localparam logic [TOL_W-1:0]  Y_TOL_RESET      = TOL_W'(66);
    localparam logic [ITER_W-1:0] ITER_LIMIT_RESET = ITER_W'(100);

    // item commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_VALUE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_PROBE     = 2'd0,
        STATUS_CONVERGED = 2'd1,
        STATUS_LIMIT     = 2'd2,
        STATUS_IGNORED   = 2'd3
    } t_status;

    // search phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH,
        PH_ITER
    } t_phase;

    // main sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_PICK,
        S_EMIT
    } t_state;

    // serial divider sequencer
    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_FIX
    } t_div_state;

    // configuration register set
    typedef struct packed {
        logic [TOL_W-1:0]  x_tol;
        logic [TOL_W-1:0]  y_tol;
        logic [ITER_W-1:0] iter_limit;
    } t_cfg;

endpackage

[rtl/irf_cfg_regs.sv]
// apb configuration registers: x tolerance, y tolerance, iteration limit
module irf_cfg_regs
    import irf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    t_cfg                 r_cfg;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_tol      <= X_TOL_RESET;
            r_cfg.y_tol      <= Y_TOL_RESET;
            r_cfg.iter_limit <= ITER_LIMIT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_X_TOL:      r_cfg.x_tol      <= pwdata[TOL_W-1:0];
                REG_Y_TOL:      r_cfg.y_tol      <= pwdata[TOL_W-1:0];
                REG_ITER_LIMIT: r_cfg.iter_limit <= pwdata[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            REG_X_TOL:      prdata = CFG_DATA_W'(r_cfg.x_tol);
            REG_Y_TOL:      prdata = CFG_DATA_W'(r_cfg.y_tol);
            REG_ITER_LIMIT: prdata = CFG_DATA_W'(r_cfg.iter_limit);
            default:        prdata = '0;
        endcase
    end

endmodule

[rtl/irf_secant_div.sv]
// serial restoring divider for the secant step, truncating and saturating quotient
module irf_secant_div
    import irf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [Q_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);
    localparam logic [QUO_W-1:0] SAT_MAG   = {1'b1, {(QUO_W-1){1'b0}}};

    t_div_state             r_dstate, n_dstate;
    logic [CNT_W-1:0]       r_cnt;
    logic [DEN_W-1:0]       r_rem;
    logic [QUO_W-1:0]       r_quo;
    logic [DEN_W-1:0]       r_den_mag;
    logic                   r_neg;
    logic                   r_sat;
    logic                   r_done;
    logic signed [Q_W-1:0]  r_q;

    logic [NUM_W-1:0]       num_mag;
    logic [DEN_W-1:0]       den_mag;
    logic [NUM_W-QUO_W-1:0] num_top;
    logic                   pre_sat;
    logic [DEN_W:0]         trial;
    logic [DEN_W:0]         trial_diff;
    logic                   trial_ge;
    logic [QUO_W-1:0]       fix_mag;
    logic signed [Q_W-1:0]  fix_pos;
    logic                   load_en;
    logic                   step_en;
    logic                   fix_en;

    // operand magnitudes and early saturation check
    assign num_mag = i_num[NUM_W-1] ? -i_num : i_num;
    assign den_mag = i_den[DEN_W-1] ? -i_den : i_den;
    assign num_top = num_mag[NUM_W-1:QUO_W];
    assign pre_sat = DEN_W'(num_top) >= den_mag;

    // one quotient bit per step
    assign trial      = {r_rem, r_quo[QUO_W-1]};
    assign trial_diff = trial - {1'b0, r_den_mag};
    assign trial_ge   = trial >= {1'b0, r_den_mag};

    // clamp to the saturation bound and apply the sign
    assign fix_mag = (r_sat || (r_quo > SAT_MAG)) ? SAT_MAG : r_quo;
    assign fix_pos = $signed({1'b0, fix_mag});

    // next state
    always_comb begin
        n_dstate = r_dstate;
        unique case (r_dstate)
            DV_IDLE: if (i_start) begin
                n_dstate = pre_sat ? DV_FIX : DV_RUN;
            end
            DV_RUN: if (r_cnt == LAST_STEP) begin
                n_dstate = DV_FIX;
            end
            DV_FIX:  n_dstate = DV_IDLE;
            default: n_dstate = DV_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        load_en = 1'b0;
        step_en = 1'b0;
        fix_en  = 1'b0;
        unique case (r_dstate)
            DV_IDLE: load_en = i_start;
            DV_RUN:  step_en = 1'b1;
            DV_FIX:  fix_en  = 1'b1;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dstate <= DV_IDLE;
            r_done   <= 1'b0;
        end else begin
            r_dstate <= n_dstate;
            r_done   <= fix_en;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_rem     <= DEN_W'(num_top);
            r_quo     <= num_mag[QUO_W-1:0];
            r_den_mag <= den_mag;
            r_neg     <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_sat     <= pre_sat;
            r_cnt     <= '0;
        end else if (step_en) begin
            r_rem <= trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], trial_ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (fix_en) begin
            r_q <= r_neg ? -fix_pos : fix_pos;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[rtl/illinois_root_finder_top.sv]
// illinois regula falsi root finder: item sequencer, probe datapath and result register
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_cmd i_bracket_low i_bracket_high i_f_value
//   result    out        o_out_valid / i_out_stall  o_status o_x_out o_iterations
//   config    apb        psel penable pwrite pready paddr pwdata prdata
//
// a start item, an ignored item, the second end probe and a final result go from
// acceptance via S_EMIT to the result register; an item that needs a new probe first
// passes S_MUL, S_DSTART, S_DIV (serial divider, one quotient bit per cycle, 34 bits)
// and S_PICK; S_DIV is skipped for equal end values and cut short on early saturation.
// one item at a time: o_in_stall is high from acceptance until its result is registered.
// a result held by i_out_stall delays the handover of the next result, and so the next accept.
// reset is synchronous; configuration returns to x tol 0, y tol 66, limit 100.
module illinois_root_finder_top
    import irf_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input items
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_cmd,
    input  logic signed [DATA_WIDTH-1:0] i_bracket_low,
    input  logic signed [DATA_WIDTH-1:0] i_bracket_high,
    input  logic signed [DATA_WIDTH-1:0] i_f_value,
    // result items
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic signed [DATA_WIDTH-1:0] o_x_out,
    output logic [ITER_W-1:0]            o_iterations,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [CFG_DATA_W-1:0]        pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int DW = DATA_WIDTH;

    t_cfg cfg;

    // sequencer
    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    // search state
    logic signed [DW-1:0]     r_low_end, n_low_end;
    logic signed [DW-1:0]     r_high_end, n_high_end;
    logic signed [DW-1:0]     r_low_val, n_low_val;
    logic signed [DW-1:0]     r_high_val, n_high_val;
    logic signed [DW-1:0]     r_best_x, n_best_x;
    logic [DW-1:0]            r_best_abs, n_best_abs;
    logic signed [DW-1:0]     r_probe, n_probe;
    logic [ITER_W-1:0]        r_iter_cnt, n_iter_cnt;

    // probe datapath
    logic signed [NUM_W-1:0]  r_num;
    logic signed [DEN_W-1:0]  r_den;
    logic signed [DEN_W-1:0]  span;
    logic [DEN_W-1:0]         width;
    logic signed [DEN_W-1:0]  den_next;
    logic signed [NUM_W-1:0]  prod;
    logic                     den_nonzero;
    logic                     div_done;
    logic signed [Q_W-1:0]    div_quot;
    logic signed [XS_W-1:0]   xs;
    logic signed [XS_W-1:0]   xl_ext;
    logic signed [XS_W-1:0]   xh_ext;
    logic                     xs_inside;
    logic signed [DEN_W-1:0]  mid_sum;
    logic signed [DW-1:0]     pick_x;

    // item decode
    logic [DW-1:0]            f_abs;
    logic                     f_neg;
    logic                     f_pos;
    logic                     hv_neg;
    logic                     hv_pos;
    logic [ITER_W-1:0]        iter_inc;
    logic                     dec_need_probe;
    t_status                  dec_status;
    logic signed [DW-1:0]     dec_x;
    logic [ITER_W-1:0]        dec_iter;

    // pending and output results
    t_status                  r_res_status;
    logic signed [DW-1:0]     r_res_x;
    logic [ITER_W-1:0]        r_res_iter;
    logic                     r_out_valid, n_out_valid;
    t_status                  r_out_status;
    logic signed [DW-1:0]     r_out_x;
    logic [ITER_W-1:0]        r_out_iter;

    // sequencer controls
    logic                     in_accept;
    logic                     mul_en;
    logic                     div_start;
    logic                     pick_en;
    logic                     load_out;
    logic                     out_free;

    irf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    irf_secant_div u_secant_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // bracket span, its width and the secant operands
    assign span     = DEN_W'(r_high_end) - DEN_W'(r_low_end);
    assign width    = span[DEN_W-1] ? -span : span;
    assign den_next = DEN_W'(r_high_val) - DEN_W'(r_low_val);
    assign prod     = NUM_W'(r_high_val) * NUM_W'(span);
    assign den_nonzero = (r_den != '0);

    // secant point, strict inside test and midpoint
    assign xl_ext    = XS_W'(r_low_end);
    assign xh_ext    = XS_W'(r_high_end);
    assign xs        = xh_ext - XS_W'(div_quot);
    assign xs_inside = ((xs > xl_ext) && (xs < xh_ext)) || ((xs > xh_ext) && (xs < xl_ext));
    assign mid_sum   = DEN_W'(r_low_end) + DEN_W'(r_high_end);
    assign pick_x    = (den_nonzero && xs_inside) ? xs[DW-1:0] : mid_sum[DW:1];

    // value item features
    assign f_abs    = i_f_value[DW-1] ? -i_f_value : i_f_value;
    assign f_neg    = i_f_value[DW-1];
    assign f_pos    = !i_f_value[DW-1] && (i_f_value != '0);
    assign hv_neg   = r_high_val[DW-1];
    assign hv_pos   = !r_high_val[DW-1] && (r_high_val != '0);
    assign iter_inc = r_iter_cnt + ITER_W'(1);

    // item decode: search state update and immediate result
    always_comb begin
        n_low_end      = r_low_end;
        n_high_end     = r_high_end;
        n_low_val      = r_low_val;
        n_high_val     = r_high_val;
        n_best_x       = r_best_x;
        n_best_abs     = r_best_abs;
        n_probe        = r_probe;
        n_iter_cnt     = r_iter_cnt;
        n_phase        = r_phase;
        dec_need_probe = 1'b0;
        dec_status     = STATUS_IGNORED;
        dec_x          = '0;
        dec_iter       = '0;
        if (i_cmd == CMD_START) begin
            n_low_end  = i_bracket_low;
            n_high_end = i_bracket_high;
            n_low_val  = '0;
            n_high_val = '0;
            n_best_x   = i_bracket_low;
            n_best_abs = '0;
            n_iter_cnt = '0;
            n_probe    = i_bracket_low;
            n_phase    = PH_LOW;
            dec_status = STATUS_PROBE;
            dec_x      = i_bracket_low;
        end else begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_LOW: begin
                    n_low_val  = i_f_value;
                    n_best_abs = f_abs;
                    n_best_x   = r_low_end;
                    n_probe    = r_high_end;
                    n_phase    = PH_HIGH;
                    dec_status = STATUS_PROBE;
                    dec_x      = r_high_end;
                end
                PH_HIGH: begin
                    n_high_val = i_f_value;
                    if (f_abs < r_best_abs) begin
                        n_best_abs = f_abs;
                        n_best_x   = r_high_end;
                    end
                    n_iter_cnt = '0;
                    if (n_best_abs < DW'(cfg.y_tol)) begin
                        n_phase    = PH_IDLE;
                        dec_status = STATUS_CONVERGED;
                        dec_x      = n_best_x;
                    end else if (cfg.iter_limit == '0) begin
                        n_phase    = PH_IDLE;
                        dec_status = STATUS_LIMIT;
                        dec_x      = n_best_x;
                    end else begin
                        n_phase        = PH_ITER;
                        dec_need_probe = 1'b1;
                    end
                end
                PH_ITER: begin
                    if (f_abs < r_best_abs) begin
                        n_best_abs = f_abs;
                        n_best_x   = r_probe;
                    end
                    if ((f_abs < DW'(cfg.y_tol)) ||
                        ((cfg.x_tol != '0) && (width < DEN_W'(cfg.x_tol)))) begin
                        n_phase    = PH_IDLE;
                        dec_status = STATUS_CONVERGED;
                        dec_x      = r_probe;
                        dec_iter   = iter_inc;
                    end else begin
                        // sign change keeps the old high end, else halve the retained value
                        if ((f_neg && hv_pos) || (f_pos && hv_neg)) begin
                            n_low_end = r_high_end;
                            n_low_val = r_high_val;
                        end else begin
                            n_low_val = r_low_val >>> 1;
                        end
                        n_high_end = r_probe;
                        n_high_val = i_f_value;
                        n_iter_cnt = iter_inc;
                        if (iter_inc >= cfg.iter_limit) begin
                            n_phase    = PH_IDLE;
                            dec_status = STATUS_LIMIT;
                            dec_x      = n_best_x;
                            dec_iter   = iter_inc;
                        end else begin
                            dec_need_probe = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) begin
                n_state = dec_need_probe ? S_MUL : S_EMIT;
            end
            S_MUL:    n_state = S_DSTART;
            S_DSTART: n_state = den_nonzero ? S_DIV : S_PICK;
            S_DIV:    if (div_done) begin
                n_state = S_PICK;
            end
            S_PICK:   n_state = S_EMIT;
            S_EMIT:   if (out_free) begin
                n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        in_accept = 1'b0;
        mul_en    = 1'b0;
        div_start = 1'b0;
        pick_en   = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            S_IDLE:   in_accept = i_in_valid;
            S_MUL:    mul_en    = 1'b1;
            S_DSTART: div_start = den_nonzero;
            S_PICK:   pick_en   = 1'b1;
            S_EMIT:   load_out  = out_free;
            default: ;
        endcase
    end

    assign n_out_valid = load_out || (r_out_valid && i_out_stall);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (in_accept) begin
                r_phase <= n_phase;
            end
        end
    end

    // search state, probe datapath and results
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_low_end    <= n_low_end;
            r_high_end   <= n_high_end;
            r_low_val    <= n_low_val;
            r_high_val   <= n_high_val;
            r_best_x     <= n_best_x;
            r_best_abs   <= n_best_abs;
            r_probe      <= n_probe;
            r_iter_cnt   <= n_iter_cnt;
            r_res_status <= dec_status;
            r_res_x      <= dec_x;
            r_res_iter   <= dec_iter;
        end
        if (mul_en) begin
            r_num <= prod;
            r_den <= den_next;
        end
        if (pick_en) begin
            r_probe      <= pick_x;
            r_res_status <= STATUS_PROBE;
            r_res_x      <= pick_x;
            r_res_iter   <= '0;
        end
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_x      <= r_res_x;
            r_out_iter   <= r_res_iter;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_x_out      = r_out_x;
    assign o_iterations = r_out_iter;

endmodule

[rtl/irf_checker.sv]
// port level checks for the root finder, bound to the top level
module irf_checker
    import irf_pkg::*;
(
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [1:0]                   o_status,
    input logic signed [DATA_WIDTH-1:0] o_x_out,
    input logic [ITER_W-1:0]            o_iterations
);

    // one item at a time: an accepted item closes the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again straight after an accepted item");

    // a held result does not change
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_status) && $stable(o_x_out) && $stable(o_iterations)))
        else $error("stalled result changed or vanished");

    // probe requests and ignored items carry no iteration count
    a_iter_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_status == STATUS_PROBE) || (o_status == STATUS_IGNORED)))
        |-> (o_iterations == '0))
        else $error("iteration count on a probe or ignored result");

    // ignored items return zero x
    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STATUS_IGNORED)) |-> (o_x_out == '0))
        else $error("ignored item returned a nonzero point");

endmodule

bind illinois_root_finder_top irf_checker u_irf_checker (.*);
